@@ sv/html_text_extractor_unit_assert.svh @@
// Assertion macros used by the HTML text extractor datapath.
`ifndef HTML_TEXT_EXTRACTOR_UNIT_ASSERT_SVH
`define HTML_TEXT_EXTRACTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define HTE_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define HTE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");
`else
`define HTE_ASSERT(lbl, expr)
`define HTE_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

@@ sv/hte_pkg.sv @@
// Shared types, constants and helpers for the HTML text extractor.
package hte_pkg;

    localparam int HOLD_DEPTH = 16;
    localparam int HOLD_AW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int HOLD_CW    = $clog2(HOLD_DEPTH + 1);
    localparam int WIN_DEPTH  = 6;
    localparam int TAG_KEEP   = 9;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [20:0] CP_IDEO_SPACE = 21'h3000;

    localparam logic [7:0] ENT_TXT [6][6] = '{
        '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B},
        '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
        '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
        '{8'h26, 8'h23, 8'h33, 8'h39, 8'h3B, 8'h00}
    };
    localparam logic [2:0] ENT_LEN [6] = '{3'd6, 3'd4, 3'd4, 3'd5, 3'd6, 3'd5};
    localparam logic [7:0] ENT_CHAR [6] = '{8'h20, 8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27};

    localparam logic [7:0] NAME_TXT [16][8] = '{
        '{8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h2F, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h64, 8'h69, 8'h76, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h2F, 8'h64, 8'h69, 8'h76, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h73, 8'h65, 8'h63, 8'h74, 8'h69, 8'h6F, 8'h6E, 8'h00},
        '{8'h2F, 8'h73, 8'h65, 8'h63, 8'h74, 8'h69, 8'h6F, 8'h6E},
        '{8'h66, 8'h69, 8'h67, 8'h75, 8'h72, 8'h65, 8'h00, 8'h00},
        '{8'h2F, 8'h66, 8'h69, 8'h67, 8'h75, 8'h72, 8'h65, 8'h00},
        '{8'h69, 8'h6D, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h62, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h2F, 8'h6C, 8'h69, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6C, 8'h69, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h2F, 8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h68, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h68, 8'h32, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h68, 8'h33, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] NAME_LEN [16] = '{
        4'd1, 4'd2, 4'd3, 4'd4, 4'd7, 4'd8, 4'd6, 4'd7,
        4'd3, 4'd2, 4'd3, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2
    };

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_item;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic take;
        logic push;
        logic finish;
        logic close;
    } hte_cmd_t;

    typedef struct packed {
        logic plan_wait;
        logic win_empty;
        logic push_done;
        logic out_free;
        logic end_item;
    } hte_status_t;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_cjk(input logic [20:0] cp);
        return (cp >= 21'h4E00 && cp <= 21'h9FFF) || (cp >= 21'h3400 && cp <= 21'h4DBF) ||
               (cp >= 21'h20000 && cp <= 21'h2A6DF) || (cp >= 21'h2A700 && cp <= 21'h2B81F) ||
               (cp >= 21'hF900 && cp <= 21'hFAFF) || (cp >= 21'h3100 && cp <= 21'h312F) ||
               (cp >= 21'h31A0 && cp <= 21'h31BF);
    endfunction

    function automatic logic is_alnum(input logic [20:0] cp);
        return (cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A) ||
               (cp >= 21'h30 && cp <= 21'h39);
    endfunction

endpackage

@@ sv/hte_ctrl.sv @@
// Sequencer for the HTML text extractor: accept, decide, push, finish, close.
module hte_ctrl
    import hte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  hte_status_t status,
    output hte_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAKE,
        S_PUSH,
        S_FINISH,
        S_CLOSE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (byte_valid) state_next = S_TAKE;
            S_TAKE:
            begin
                if (status.plan_wait || status.win_empty) state_next = S_FINISH;
                else state_next = S_PUSH;
            end
            S_PUSH:   if (status.push_done) state_next = S_TAKE;
            S_FINISH: state_next = status.end_item ? S_CLOSE : S_IDLE;
            S_CLOSE:  if (status.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    always_comb
    begin
        byte_ready = (state_reg == S_IDLE);
        cmd.load   = (state_reg == S_IDLE) && byte_valid;
        cmd.take   = (state_reg == S_TAKE) && !status.plan_wait && !status.win_empty;
        cmd.push   = (state_reg == S_PUSH);
        cmd.finish = (state_reg == S_FINISH);
        cmd.close  = (state_reg == S_CLOSE);
    end

endmodule

@@ sv/hte_datapath.sv @@
// Window, decode, tag/entity/UTF-8 logic, blank FIFO and output register.
module hte_datapath
    import hte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  hte_cmd_t    cmd,
    input  in_item_t    byte_req,
    output hte_status_t status,
    output logic        text_valid,
    input  logic        text_ready,
    output out_item_t   text_req
);

`include "html_text_extractor_unit_assert.svh"

    logic [7:0]  win_reg [WIN_DEPTH];
    logic [2:0]  n_reg, pos_reg;
    logic        end_reg;
    logic        inside_reg;
    logic [3:0]  tlen_reg;
    logic [7:0]  head_reg [TAG_KEEP];
    logic [20:0] prev_reg;
    logic        indent_reg, wrote_reg;
    logic [7:0]  last_reg;
    logic [7:0]  hold_reg [HOLD_DEPTH];
    logic [HOLD_AW-1:0] rd_reg, wr_reg;
    logic [HOLD_CW-1:0] hcnt_reg;
    logic [7:0]  pb_reg [8];
    logic [3:0]  pcnt_reg, idx_reg;
    logic        ov_reg, ol_reg;
    logic [7:0]  ob_reg;

    logic [7:0]  v [WIN_DEPTH];
    logic [2:0]  avail;
    logic        p_wait;
    logic [2:0]  p_cons;
    logic [7:0]  p_pb [8];
    logic [3:0]  p_cnt;
    logic        p_inside, p_indent, p_wrote;
    logic [3:0]  p_tlen;
    logic [20:0] p_prev;
    logic [7:0]  p_last;
    logic        blk;
    logic        out_free;

    always_comb
    begin
        logic [3:0] ix;
        for (int k = 0; k < WIN_DEPTH; k++)
        begin
            ix = {1'b0, pos_reg} + 4'(k);
            v[k] = (ix < 4'(WIN_DEPTH)) ? win_reg[ix[2:0]] : 8'h00;
        end
        avail = n_reg - pos_reg;
    end

    always_comb
    begin
        logic m;
        blk = 1'b0;
        for (int e = 0; e < 16; e++)
        begin
            m = (tlen_reg >= NAME_LEN[e]);
            for (int i = 0; i < 8; i++)
                if (4'(i) < NAME_LEN[e] && head_reg[i] != NAME_TXT[e][i]) m = 1'b0;
            if (tlen_reg != NAME_LEN[e])
                m = m && (head_reg[NAME_LEN[e]] == CH_SPACE || head_reg[NAME_LEN[e]] == CH_SLASH);
            if (m) blk = 1'b1;
        end
    end

    always_comb
    begin
        logic [7:0]  b;
        logic        handled, ok, stop, sp;
        logic [2:0]  len, use_n;
        logic [20:0] cp, pe;
        logic [3:0]  o;
        b = v[0];
        p_wait = 1'b0;
        p_cons = 3'd1;
        p_cnt = 4'd0;
        for (int k = 0; k < 8; k++) p_pb[k] = 8'h00;
        p_inside = inside_reg;
        p_tlen = tlen_reg;
        p_prev = prev_reg;
        p_indent = indent_reg;
        p_wrote = wrote_reg;
        p_last = last_reg;
        handled = 1'b0;
        ok = 1'b0;
        stop = 1'b0;
        sp = 1'b0;
        len = 3'd1;
        use_n = 3'd1;
        cp = {13'd0, b};
        pe = prev_reg;
        o = 4'd0;
        if (inside_reg)
        begin
            if (b == CH_GT)
            begin
                if (blk && wrote_reg && last_reg != CH_LF)
                begin
                    p_pb[0] = CH_LF;
                    p_cnt = 4'd1;
                    p_prev = {13'd0, CH_LF};
                    p_indent = 1'b1;
                    p_last = CH_LF;
                end
                p_inside = 1'b0;
                p_tlen = 4'd0;
            end
            else if (tlen_reg != 4'd15)
                p_tlen = tlen_reg + 4'd1;
        end
        else if (b == CH_LT)
        begin
            p_inside = 1'b1;
            p_tlen = 4'd0;
        end
        else
        begin
            if (b == CH_AMP)
            begin
                for (int e = 0; e < 6; e++)
                begin
                    if (!handled)
                    begin
                        ok = 1'b1;
                        for (int k = 1; k < 6; k++)
                            if (3'(k) < ENT_LEN[e] && 3'(k) < avail && v[k] != ENT_TXT[e][k])
                                ok = 1'b0;
                        if (ok)
                        begin
                            if (avail >= ENT_LEN[e])
                            begin
                                p_pb[0] = ENT_CHAR[e];
                                p_cnt = 4'd1;
                                p_cons = ENT_LEN[e];
                                p_prev = {13'd0, ENT_CHAR[e]};
                                p_wrote = 1'b1;
                                p_last = ENT_CHAR[e];
                                handled = 1'b1;
                            end
                            else if (!end_reg)
                            begin
                                p_wait = 1'b1;
                                handled = 1'b1;
                            end
                        end
                    end
                end
            end
            if (!handled && b == CH_CR) handled = 1'b1;
            else if (!handled && b == CH_LF)
            begin
                handled = 1'b1;
                if (wrote_reg && last_reg != CH_LF)
                begin
                    p_pb[0] = CH_LF;
                    p_cnt = 4'd1;
                    p_prev = {13'd0, CH_LF};
                    p_indent = 1'b1;
                    p_last = CH_LF;
                end
            end
            if (!handled)
            begin
                if (b[7] == 1'b0) len = 3'd1;
                else if (b[7:5] == 3'b110) len = 3'd2;
                else if (b[7:4] == 4'b1110) len = 3'd3;
                else if (b[7:3] == 5'b11110) len = 3'd4;
                else len = 3'd1;
                ok = 1'b1;
                for (int k = 1; k < 4; k++)
                begin
                    if (!stop && 3'(k) < len)
                    begin
                        if (3'(k) >= avail)
                        begin
                            if (!end_reg) p_wait = 1'b1;
                            ok = 1'b0;
                            stop = 1'b1;
                        end
                        else if (v[k][7:6] != 2'b10)
                        begin
                            ok = 1'b0;
                            stop = 1'b1;
                        end
                    end
                end
                if (ok && len == 3'd2)
                    cp = {10'd0, b[4:0], v[1][5:0]};
                else if (ok && len == 3'd3)
                    cp = {5'd0, b[3:0], v[1][5:0], v[2][5:0]};
                else if (ok && len == 3'd4)
                    cp = {b[2:0], v[1][5:0], v[2][5:0], v[3][5:0]};
                use_n = ok ? len : 3'd1;
                p_cons = use_n;
                if (!p_wait && !(indent_reg && (cp == 21'h20 || cp == 21'h09 ||
                                                cp == CP_IDEO_SPACE)))
                begin
                    if (indent_reg)
                    begin
                        p_pb[0] = 8'hE3;
                        p_pb[1] = 8'h80;
                        p_pb[2] = 8'h80;
                        o = 4'd3;
                        pe = CP_IDEO_SPACE;
                        p_indent = 1'b0;
                    end
                    sp = pe != 21'd0 && pe != 21'h20 && pe != 21'h0A && pe != CP_IDEO_SPACE &&
                         ((is_cjk(pe) && is_alnum(cp)) || (is_alnum(pe) && is_cjk(cp)));
                    if (sp)
                    begin
                        p_pb[o[2:0]] = CH_SPACE;
                        o = o + 4'd1;
                    end
                    for (int k = 0; k < 4; k++)
                        if (3'(k) < use_n) p_pb[3'(o + 4'(k))] = v[k];
                    p_cnt = o + {1'b0, use_n};
                    p_last = v[3'(use_n - 3'd1)];
                    p_wrote = 1'b1;
                    p_prev = cp;
                end
            end
        end
    end

    // blank FIFO / output step
    logic [7:0] cur_b;
    logic       cur_blank, hfull, hempty;
    logic       do_put, do_pop, do_enq, do_adv;
    logic [7:0] put_b;

    always_comb
    begin
        cur_b = pb_reg[idx_reg[2:0]];
        cur_blank = is_blank(cur_b);
        hfull = (hcnt_reg == HOLD_CW'(HOLD_DEPTH));
        hempty = (hcnt_reg == '0);
        out_free = !ov_reg || text_ready;
        do_put = 1'b0;
        do_pop = 1'b0;
        do_enq = 1'b0;
        do_adv = 1'b0;
        put_b = cur_b;
        if (cmd.push && idx_reg != pcnt_reg && out_free)
        begin
            if (cur_blank)
            begin
                do_enq = 1'b1;
                do_adv = 1'b1;
                if (hfull)
                begin
                    do_put = 1'b1;
                    do_pop = 1'b1;
                    put_b = hold_reg[rd_reg];
                end
            end
            else if (!hempty)
            begin
                do_put = 1'b1;
                do_pop = 1'b1;
                put_b = hold_reg[rd_reg];
            end
            else
            begin
                do_put = 1'b1;
                do_adv = 1'b1;
            end
        end
    end

    function automatic logic [HOLD_AW-1:0] ptr_inc(input logic [HOLD_AW-1:0] p);
        return (p == HOLD_AW'(HOLD_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
            pos_reg <= '0;
            end_reg <= 1'b0;
            inside_reg <= 1'b0;
            tlen_reg <= '0;
            prev_reg <= '0;
            indent_reg <= 1'b1;
            wrote_reg <= 1'b0;
            last_reg <= '0;
            rd_reg <= '0;
            wr_reg <= '0;
            hcnt_reg <= '0;
            pcnt_reg <= '0;
            idx_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                n_reg <= n_reg + 3'd1;
                pos_reg <= '0;
                end_reg <= byte_req.final_item;
            end
            if (cmd.take)
            begin
                pos_reg <= pos_reg + p_cons;
                inside_reg <= p_inside;
                tlen_reg <= p_tlen;
                prev_reg <= p_prev;
                indent_reg <= p_indent;
                wrote_reg <= p_wrote;
                last_reg <= p_last;
                pcnt_reg <= p_cnt;
                idx_reg <= '0;
            end
            if (cmd.finish)
            begin
                n_reg <= avail;
                pos_reg <= '0;
            end
            if (do_adv) idx_reg <= idx_reg + 4'd1;
            if (do_enq) wr_reg <= ptr_inc(wr_reg);
            if (do_pop) rd_reg <= ptr_inc(rd_reg);
            if (do_enq && !do_pop) hcnt_reg <= hcnt_reg + 1'b1;
            else if (do_pop && !do_enq) hcnt_reg <= hcnt_reg - 1'b1;
            if (do_put || (cmd.close && out_free)) ov_reg <= 1'b1;
            else if (text_ready) ov_reg <= 1'b0;
            if (cmd.close && out_free)
            begin
                n_reg <= '0;
                pos_reg <= '0;
                inside_reg <= 1'b0;
                tlen_reg <= '0;
                prev_reg <= '0;
                indent_reg <= 1'b1;
                wrote_reg <= 1'b0;
                last_reg <= '0;
                rd_reg <= '0;
                wr_reg <= '0;
                hcnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && n_reg < 3'(WIN_DEPTH)) win_reg[n_reg] <= byte_req.text_byte;
        if (cmd.finish)
            for (int k = 0; k < WIN_DEPTH; k++) win_reg[k] <= v[k];
        if (cmd.take && inside_reg && v[0] != CH_GT && tlen_reg < 4'(TAG_KEEP))
            head_reg[tlen_reg] <= (v[0] >= 8'h41 && v[0] <= 8'h5A) ? v[0] + 8'h20 : v[0];
        if (cmd.take)
            for (int k = 0; k < 8; k++) pb_reg[k] <= p_pb[k];
        if (do_enq) hold_reg[wr_reg] <= cur_b;
        if (do_put)
        begin
            ob_reg <= put_b;
            ol_reg <= 1'b0;
        end
        else if (cmd.close && out_free)
        begin
            ob_reg <= CH_LF;
            ol_reg <= 1'b1;
        end
    end

    assign status.plan_wait = p_wait;
    assign status.win_empty = (pos_reg == n_reg);
    assign status.push_done = (idx_reg == pcnt_reg);
    assign status.out_free  = out_free;
    assign status.end_item  = end_reg;

    assign text_valid        = ov_reg;
    assign text_req.out_byte = ob_reg;
    assign text_req.out_last = ol_reg;

    `HTE_ASSERT(a_hold_bound, hcnt_reg <= HOLD_CW'(HOLD_DEPTH))
    `HTE_ASSERT(a_pos_in_win, pos_reg <= n_reg)
    `HTE_ASSERT(a_push_idx, idx_reg <= pcnt_reg)
    `HTE_ASSERT_IMP(a_idle_win, cmd.load, n_reg <= 3'd5)
    `HTE_ASSERT_IMP(a_last_is_lf, ov_reg && ol_reg, ob_reg == CH_LF)

endmodule

@@ sv/html_text_extractor_unit.sv @@
// Top level of the HTML-to-text extractor.
// Input channel byte_valid/byte_ready/byte_req carries one HTML byte per request,
// with final_item marking the last byte of a document.
// Output channel text_valid/text_ready/text_req carries one UTF-8 text byte per
// request; out_last marks the closing LF of the document.
// One request is taken at a time. The sequencer works on a six-byte window (the
// new byte behind up to five lookahead bytes). After accepting a request it
// decodes one token in S_TAKE, then sends each emitted or held byte in S_PUSH,
// and repeats until the window is empty or must wait for lookahead; S_FINISH then
// stores the lookahead, and after the last byte S_CLOSE sends the closing LF.
// Held blanks are released in S_PUSH, ahead of the next non-blank byte or when
// the held-blank FIFO is full.
// Results go through a single output register; when the receiver stalls the
// sequencer waits on it and byte_ready stays low until the request is done.
// Reset (rst_n, asynchronous, active low) empties the lookahead window,
// tag state and the held-blank FIFO, and arms the paragraph indent.
module html_text_extractor_unit
    import hte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  in_item_t  byte_req,
    output logic      text_valid,
    input  logic      text_ready,
    output out_item_t text_req
);

    hte_cmd_t    cmd;
    hte_status_t status;

    hte_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .status     (status),
        .cmd        (cmd)
    );

    hte_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .byte_req   (byte_req),
        .status     (status),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_req   (text_req)
    );

endmodule
